// ===== design/t32lsd_pkg.sv =====
// Shared types and codes for the Thumb-32 load/store dual, exclusive and
// table-branch decoder. No dependencies.
package t32lsd_pkg;

	localparam logic [2:0] KIND_TBRANCH = 3'd0;
	localparam logic [2:0] KIND_LDA     = 3'd1;
	localparam logic [2:0] KIND_STL     = 3'd2;
	localparam logic [2:0] KIND_LDEX    = 3'd3;
	localparam logic [2:0] KIND_STEX    = 3'd4;
	localparam logic [2:0] KIND_LDD     = 3'd5;
	localparam logic [2:0] KIND_STD     = 3'd6;

	localparam logic [1:0] SZ_BYTE = 2'd0;
	localparam logic [1:0] SZ_HALF = 2'd1;
	localparam logic [1:0] SZ_WORD = 2'd2;

	localparam logic [3:0] REG_PC = 4'hF;

	typedef struct packed {
		logic [2:0] insn_kind;
		logic [3:0] target_reg;
		logic [3:0] second_reg;
		logic [3:0] base_reg;
		logic [3:0] index_reg;
		logic [3:0] status_reg;
		logic [1:0] xfer_size;
		logic [9:0] offset;
		logic       add_offset;
		logic       pre_offset;
		logic       write_back;
		logic       acq_exclusive;
	} dec_result_t;

endpackage

// ===== design/t32lsd_decode.sv =====
// Combinational field decode of one instruction of the group.
// Depends on t32lsd_pkg for the kind and size codes and the result struct.
module t32lsd_decode import t32lsd_pkg::*; (
	input  logic [15:0]  first_half,
	input  logic [15:0]  second_half,
	output dec_result_t  result
);

	logic [1:0] op1;
	logic [1:0] op2;
	logic       ld;
	logic [3:0] rt;
	logic [3:0] rt2;
	logic [3:0] variant;
	logic [9:0] imm_scaled;
	logic       is_tbranch;
	logic       is_acqrel;
	logic       is_excl;

	assign op1        = first_half[8:7];
	assign op2        = first_half[5:4];
	assign ld         = first_half[4];
	assign rt         = second_half[15:12];
	assign rt2        = second_half[11:8];
	assign variant    = second_half[7:4];
	assign imm_scaled = {second_half[7:0], 2'b00};

	assign is_tbranch = (op1 == 2'd1) && (op2 == 2'd1) && (rt == REG_PC);
	assign is_acqrel  = (rt2 == REG_PC) && variant[3];
	assign is_excl    = !op1[1] && !op2[1];

	always_comb begin
		result               = '0;
		result.target_reg    = rt;
		result.second_reg    = rt2;
		result.base_reg      = first_half[3:0];
		result.xfer_size     = SZ_WORD;
		priority if (is_tbranch) begin
			result.insn_kind   = KIND_TBRANCH;
			result.index_reg   = second_half[3:0];
			result.xfer_size   = second_half[4] ? SZ_HALF : SZ_BYTE;
		end else if (is_acqrel) begin
			result.insn_kind     = ld ? KIND_LDA : KIND_STL;
			result.acq_exclusive = variant[2];
			unique case (variant[1:0])
				2'd0:    result.xfer_size = SZ_BYTE;
				2'd1:    result.xfer_size = SZ_HALF;
				default: result.xfer_size = SZ_WORD;
			endcase
			if (!ld && variant[2]) begin
				result.status_reg = second_half[3:0];
			end
			result.add_offset = 1'b1;
		end else if (is_excl) begin
			result.insn_kind  = ld ? KIND_LDEX : KIND_STEX;
			result.add_offset = 1'b1;
			if (!first_half[7]) begin
				// Word exclusive carries a word-scaled immediate and Rd in the Rt2 slot.
				result.offset = imm_scaled;
				if (!ld) begin
					result.status_reg = rt2;
				end
			end else begin
				result.xfer_size = (second_half[5:4] == 2'd0) ? SZ_BYTE : SZ_HALF;
				if (!ld) begin
					result.status_reg = second_half[3:0];
				end
			end
		end else begin
			result.insn_kind  = ld ? KIND_LDD : KIND_STD;
			result.offset     = imm_scaled;
			result.add_offset = first_half[7];
			result.pre_offset = first_half[8];
			result.write_back = first_half[5];
		end
	end

endmodule

// ===== design/thumb32_load_store_dual_decode.sv =====
// Top level: input register, field decode, result register.
// Flow: a transaction accepted into the input register is decoded from there, then moves into
// the result register, which drives the outputs; a stall on dec_ready can hold it in either one.
// Throughput: one transaction per cycle while dec_ready is high; each stage refills as it empties.
// Reset: arst_n low clears both stage valid flags at once; payload registers are not reset.
// Depends on t32lsd_pkg and t32lsd_decode.
module thumb32_load_store_dual_decode import t32lsd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        insn_valid,
	output logic        insn_ready,
	input  logic [15:0] first_half,
	input  logic [15:0] second_half,
	output logic        dec_valid,
	input  logic        dec_ready,
	output logic [2:0]  insn_kind,
	output logic [3:0]  target_reg,
	output logic [3:0]  second_reg,
	output logic [3:0]  base_reg,
	output logic [3:0]  index_reg,
	output logic [3:0]  status_reg,
	output logic [1:0]  xfer_size,
	output logic [9:0]  offset,
	output logic        add_offset,
	output logic        pre_offset,
	output logic        write_back,
	output logic        acq_exclusive
);

	logic        valid_s1;
	logic [15:0] first_s1;
	logic [15:0] second_s1;
	logic        valid_s2;
	dec_result_t result_s2;
	dec_result_t decoded;
	logic        load_s2;
	logic        load_s1;

	// The result stage takes a new transaction whenever it is empty or being drained.
	assign load_s2    = !valid_s2 || dec_ready;
	assign load_s1    = !valid_s1 || load_s2;
	assign insn_ready = load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= insn_valid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && insn_valid) begin
			first_s1  <= first_half;
			second_s1 <= second_half;
		end
		if (load_s2 && valid_s1) begin
			result_s2 <= decoded;
		end
	end

	t32lsd_decode u_decode (
		.first_half  (first_s1),
		.second_half (second_s1),
		.result      (decoded)
	);

	assign dec_valid     = valid_s2;
	assign insn_kind     = result_s2.insn_kind;
	assign target_reg    = result_s2.target_reg;
	assign second_reg    = result_s2.second_reg;
	assign base_reg      = result_s2.base_reg;
	assign index_reg     = result_s2.index_reg;
	assign status_reg    = result_s2.status_reg;
	assign xfer_size     = result_s2.xfer_size;
	assign offset        = result_s2.offset;
	assign add_offset    = result_s2.add_offset;
	assign pre_offset    = result_s2.pre_offset;
	assign write_back    = result_s2.write_back;
	assign acq_exclusive = result_s2.acq_exclusive;

endmodule

// ===== design/t32lsd_checker.sv =====
// Port-level checks on the decoder's result channel, bound to the top level.
// Depends on t32lsd_pkg for the kind codes.
module t32lsd_checker import t32lsd_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       dec_valid,
	input logic       dec_ready,
	input logic [2:0] insn_kind,
	input logic [3:0] index_reg,
	input logic [3:0] status_reg,
	input logic [9:0] offset,
	input logic       pre_offset,
	input logic       write_back,
	input logic       acq_exclusive
);

	// A stalled result transaction stays valid and holds its kind and offset.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && !dec_ready |=> dec_valid && $stable(insn_kind) && $stable(offset))
		else $error("result changed while stalled");

	a_index: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && insn_kind != KIND_TBRANCH |-> index_reg == 4'd0)
		else $error("index register set outside a table branch");

	a_dual_flags: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && (pre_offset || write_back) |-> insn_kind == KIND_LDD || insn_kind == KIND_STD)
		else $error("addressing flags set outside a dual access");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && status_reg != 4'd0 |-> insn_kind == KIND_STEX ||
			(insn_kind == KIND_STL && acq_exclusive))
		else $error("status register set outside an exclusive store");

	a_offset: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && offset != 10'd0 |-> offset[1:0] == 2'b00 &&
			(insn_kind == KIND_LDEX || insn_kind == KIND_STEX ||
			 insn_kind == KIND_LDD || insn_kind == KIND_STD))
		else $error("offset present on a kind that carries none");

endmodule

bind thumb32_load_store_dual_decode t32lsd_checker u_t32lsd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.dec_valid     (dec_valid),
	.dec_ready     (dec_ready),
	.insn_kind     (insn_kind),
	.index_reg     (index_reg),
	.status_reg    (status_reg),
	.offset        (offset),
	.pre_offset    (pre_offset),
	.write_back    (write_back),
	.acq_exclusive (acq_exclusive)
);
